@@ hw/rtl/ajle_pkg.sv @@
`default_nettype none

package ajle_pkg;

    // Window sizing and startup latency
    localparam int WINDOW_DEPTH       = 20;
    localparam int MIN_FILL           = 5;
    localparam int INITIAL_LATENCY_MS = 40;

    // Field widths
    localparam int TIME_W     = 48;
    localparam int LAT_W      = 10;
    localparam int IVL_W      = 8;
    localparam int STAT_W     = 2;
    localparam int WCNT_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LAT_W;

    // Stream payload widths, tdata padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = STAT_W;

    // Register reset values
    localparam int MIN_LAT_RST = 20;
    localparam int MAX_LAT_RST = 200;
    localparam int MAX_IVL_RST = 200;

    // Register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IVL = 2'd2;

    // Derived storage widths
    localparam int IDX_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_MAX = (WINDOW_DEPTH > MIN_FILL) ? WINDOW_DEPTH : MIN_FILL;
    localparam int FILL_W   = $clog2(FILL_MAX + 1);
    localparam int VAL_MAX  = (2 ** IVL_W) - 1;
    localparam int VAR_MAX  = WINDOW_DEPTH * VAL_MAX * VAL_MAX;
    localparam int VAR_W    = $clog2(VAR_MAX + 1);
    localparam int OP_W     = VAR_W + (VAR_W % 2);
    localparam int ROOT_W   = OP_W / 2;
    localparam int REM_W    = ROOT_W + FILL_W + 2;
    localparam int CNT_W    = $clog2(OP_W + 1);
    localparam int TGT_W    = ROOT_W + 2;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_FIRST   = 2'd0,
        ST_REJECT  = 2'd1,
        ST_WARMUP  = 2'd2,
        ST_UPDATED = 2'd3
    } status_t;

    // Shared divide / square root unit handshake
    typedef struct packed {
        logic              start;
        logic              is_sqrt;
        logic [OP_W-1:0]   operand;
        logic [FILL_W-1:0] divisor;
    } iter_req_t;

    typedef struct packed {
        logic            done;
        logic [OP_W-1:0] result;
    } iter_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ajle_iter_unit.sv @@
`default_nettype none

// Shared restoring divide / digit-by-digit square root: one compare and
// subtract per cycle. Division takes OP_W steps, square root OP_W/2.
module ajle_iter_unit import ajle_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire iter_req_t req,
    output iter_rsp_t      rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic              sqrt_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [OP_W-1:0]   opnd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [OP_W-1:0]   q_reg;
    logic [FILL_W-1:0] div_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_diff;
    logic              ge;
    logic [REM_W-1:0]  rem_next;
    logic [OP_W-1:0]   q_next;

    // Bring down the next digit and try the subtraction
    always_comb begin
        if (sqrt_reg) begin
            rem_sh = {rem_reg, opnd_reg[OP_W-1 -: 2]};
            trial  = {q_reg[REM_W-1:0], 2'b01};
        end else begin
            rem_sh = {1'b0, rem_reg, opnd_reg[OP_W-1]};
            trial  = (REM_W+2)'(div_reg);
        end
        ge       = (rem_sh >= trial);
        rem_diff = rem_sh - trial;
        rem_next = ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        q_next   = {q_reg[OP_W-2:0], ge};
    end

    // Sequence the steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == CNT_W'(1));
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == CNT_W'(1))) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Operand, partial remainder and quotient
    always_ff @(posedge aclk) begin
        if (req.start) begin
            sqrt_reg <= req.is_sqrt;
            opnd_reg <= req.operand;
            div_reg  <= req.divisor;
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= req.is_sqrt ? CNT_W'(ROOT_W) : CNT_W'(OP_W);
        end else if (busy_reg) begin
            opnd_reg <= sqrt_reg ? (opnd_reg << 2) : (opnd_reg << 1);
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = q_reg;

endmodule

`default_nettype wire

@@ hw/rtl/adaptive_jitter_latency_estimator_top.sv @@
`default_nettype none

// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    s_tdata: arrival_time_ms
// m_        out  m_tvalid / m_tready    m_tdata: latency_ms, window_count; m_tuser: status
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// A first arrival, a rejected interval or a warming-up window gives its
// result in the cycle after the transaction. A latency update walks the
// window twice through the single read port and uses the shared divide/sqrt
// unit three times. Reset is synchronous, active low; the window store
// needs no clearing. Input is held off while an update runs and until the
// result register is free or being drained.
module adaptive_jitter_latency_estimator_top import ajle_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [47:0] arrival_time_ms
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [9:0] latency_ms, [14:10] window_count
    output logic [M_TUSER_W-1:0]       m_tuser,   // [1:0] status
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SUM     = 6'b000010,
        S_DIV_AVG = 6'b000100,
        S_VAR     = 6'b001000,
        S_DIV_VAR = 6'b010000,
        S_SQRT    = 6'b100000
    } state_t;

    state_t              state_reg;
    logic [LAT_W-1:0]    min_lat_reg;
    logic [LAT_W-1:0]    max_lat_reg;
    logic [IVL_W-1:0]    max_ivl_reg;
    logic [TIME_W-1:0]   prev_reg;
    logic                have_prev_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [LAT_W-1:0]    cur_lat_reg;
    logic [FILL_W-1:0]   idx_reg;
    logic [VAR_W-1:0]    acc_reg;
    logic [IVL_W-1:0]    avg_reg;
    logic                rd_valid_reg;
    logic [IVL_W-1:0]    rd_data_reg;
    logic                sq_valid_reg;
    logic [2*IVL_W-1:0]  sq_reg;
    logic                m_tvalid_reg;
    logic [LAT_W-1:0]    out_lat_reg;
    status_t             out_stat_reg;
    logic [WCNT_W-1:0]   out_cnt_reg;

    logic [IVL_W-1:0]    win_mem [WINDOW_DEPTH];

    logic                accept;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   diff;
    logic                backwards;
    logic                in_range;
    logic                keep;
    logic [FILL_W-1:0]   fill_inc;
    logic [IDX_W-1:0]    head_inc;
    logic                warm;
    logic                rd_go;
    logic                sum_done;
    logic                var_done;
    logic [IVL_W-1:0]    dev;
    logic [ROOT_W-1:0]   stddev;
    logic [TGT_W-1:0]    target;
    logic [TGT_W-1:0]    raised;
    logic [LAT_W-1:0]    clamped;
    logic [LAT_W+1:0]    lat_sum;
    logic [LAT_W-1:0]    lat_new;
    logic                out_load;
    logic [LAT_W-1:0]    out_lat_next;
    status_t             out_stat_next;
    logic [FILL_W-1:0]   out_fill_next;
    iter_req_t           iter_req;
    iter_rsp_t           iter_rsp;

    ajle_iter_unit u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iter_req),
        .rsp     (iter_rsp)
    );

    // Input side: interval, range check and window bookkeeping
    assign s_tready  = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign now       = s_tdata[TIME_W-1:0];
    assign diff      = now - prev_reg;
    assign backwards = (now < prev_reg);
    assign in_range  = (diff[TIME_W-1:IVL_W] == '0) && (diff[IVL_W-1:0] <= max_ivl_reg);
    assign keep      = have_prev_reg && !backwards && in_range;
    assign fill_inc  = (fill_reg < FILL_W'(WINDOW_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
    assign head_inc  = (head_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign warm      = (fill_inc < FILL_W'(MIN_FILL));

    // Window walk control
    assign rd_go    = (idx_reg < fill_reg);
    assign sum_done = (state_reg == S_SUM) && (idx_reg == fill_reg) && !rd_valid_reg;
    assign var_done = (state_reg == S_VAR) && (idx_reg == fill_reg) && !rd_valid_reg
                      && !sq_valid_reg;
    assign dev      = (rd_data_reg >= avg_reg) ? rd_data_reg - avg_reg : avg_reg - rd_data_reg;

    // Launch divide by fill after each walk, then square root of the variance
    always_comb begin
        iter_req.start   = sum_done || var_done || ((state_reg == S_DIV_VAR) && iter_rsp.done);
        iter_req.is_sqrt = (state_reg == S_DIV_VAR);
        iter_req.operand = (state_reg == S_DIV_VAR) ? iter_rsp.result : OP_W'(acc_reg);
        iter_req.divisor = fill_reg;
    end

    // Target = avg + 2*stddev, clamp, then smooth toward it
    always_comb begin
        stddev  = iter_rsp.result[ROOT_W-1:0];
        target  = TGT_W'(avg_reg) + {1'b0, stddev, 1'b0};
        raised  = (target < TGT_W'(min_lat_reg)) ? TGT_W'(min_lat_reg) : target;
        clamped = (raised > TGT_W'(max_lat_reg)) ? max_lat_reg : raised[LAT_W-1:0];
        lat_sum = {2'b00, cur_lat_reg} + {1'b0, cur_lat_reg, 1'b0} + {2'b00, clamped};
        lat_new = lat_sum[LAT_W+1:2];
    end

    // Select what goes into the result register
    always_comb begin
        out_load      = 1'b0;
        out_lat_next  = cur_lat_reg;
        out_stat_next = ST_FIRST;
        out_fill_next = fill_reg;
        if (accept) begin
            if (!have_prev_reg) begin
                out_load = 1'b1;
            end else if (!keep) begin
                out_load      = 1'b1;
                out_stat_next = ST_REJECT;
            end else if (warm) begin
                out_load      = 1'b1;
                out_stat_next = ST_WARMUP;
                out_fill_next = fill_inc;
            end
        end else if ((state_reg == S_SQRT) && iter_rsp.done) begin
            out_load      = 1'b1;
            out_lat_next  = lat_new;
            out_stat_next = ST_UPDATED;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            min_lat_reg   <= LAT_W'(MIN_LAT_RST);
            max_lat_reg   <= LAT_W'(MAX_LAT_RST);
            max_ivl_reg   <= IVL_W'(MAX_IVL_RST);
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            fill_reg      <= '0;
            head_reg      <= '0;
            cur_lat_reg   <= LAT_W'(INITIAL_LATENCY_MS);
            rd_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // Config writes
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MIN_LAT: min_lat_reg <= cfg_wdata;
                    REG_MAX_LAT: max_lat_reg <= cfg_wdata;
                    REG_MAX_IVL: max_ivl_reg <= cfg_wdata[IVL_W-1:0];
                    default: ;
                endcase
            end

            // Raise valid on a new load, else drop the result once taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            rd_valid_reg <= ((state_reg == S_SUM) || (state_reg == S_VAR)) && rd_go;
            sq_valid_reg <= (state_reg == S_VAR) && rd_valid_reg;

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        have_prev_reg <= 1'b1;
                        prev_reg      <= now;
                        if (keep) begin
                            head_reg <= head_inc;
                            fill_reg <= fill_inc;
                            if (!warm) begin
                                state_reg <= S_SUM;
                            end
                        end
                    end
                end
                S_SUM: begin
                    if (sum_done) begin
                        state_reg <= S_DIV_AVG;
                    end
                end
                S_DIV_AVG: begin
                    if (iter_rsp.done) begin
                        state_reg <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (var_done) begin
                        state_reg <= S_DIV_VAR;
                    end
                end
                S_DIV_VAR: begin
                    if (iter_rsp.done) begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (iter_rsp.done) begin
                        cur_lat_reg <= lat_new;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Window walks: sum, then squared deviations from the mean
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                idx_reg <= '0;
                acc_reg <= '0;
            end
            S_SUM: begin
                if (rd_go) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (rd_valid_reg) begin
                    acc_reg <= acc_reg + VAR_W'(rd_data_reg);
                end
            end
            S_DIV_AVG: begin
                idx_reg <= '0;
                acc_reg <= '0;
                if (iter_rsp.done) begin
                    avg_reg <= iter_rsp.result[IVL_W-1:0];
                end
            end
            S_VAR: begin
                if (rd_go) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                sq_reg <= (2*IVL_W)'(dev) * (2*IVL_W)'(dev);
                if (sq_valid_reg) begin
                    acc_reg <= acc_reg + VAR_W'(sq_reg);
                end
            end
            default: ;
        endcase
    end

    // Interval window store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && keep) begin
            win_mem[head_reg] <= diff[IVL_W-1:0];
        end
        rd_data_reg <= win_mem[idx_reg[IDX_W-1:0]];
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_lat_reg  <= out_lat_next;
            out_stat_reg <= out_stat_next;
            out_cnt_reg  <= WCNT_W'(out_fill_next);
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_TDATA_W'({out_cnt_reg, out_lat_reg});
    assign m_tuser   = out_stat_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ sim/adaptive_jitter_latency_estimator_top_tb.sv @@
module adaptive_jitter_latency_estimator_top_tb;
    import ajle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 110;
    localparam int NUM_PHASES  = 8;
    localparam int DRAIN_WAIT  = 120;

    // Index past the register list, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [LAT_W-1:0]  latency;
        status_t           status;
        logic [WCNT_W-1:0] wcount;
    } jitter_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [47:0] arrival_time_ms
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [9:0] latency_ms, [14:10] window_count
    logic [M_TUSER_W-1:0]  m_tuser;          // [1:0] status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the estimator registers and state
    logic [LAT_W-1:0]  cfg_min_lat   = LAT_W'(MIN_LAT_RST);
    logic [LAT_W-1:0]  cfg_max_lat   = LAT_W'(MAX_LAT_RST);
    logic [IVL_W-1:0]  cfg_max_ivl   = IVL_W'(MAX_IVL_RST);
    logic [TIME_W-1:0] prev_arrival  = '0;
    bit                have_arrival  = 1'b0;
    logic [IVL_W-1:0]  ivl_hist [WINDOW_DEPTH];
    int                hist_fill     = 0;
    int                hist_head     = 0;
    logic [LAT_W-1:0]  cur_latency   = LAT_W'(INITIAL_LATENCY_MS);

    jitter_result_t    expected_results[$];
    logic [TIME_W-1:0] last_sent     = '0;
    int                burst_left    = 0;
    int                error_count   = 0;
    int                cycle_count   = 0;
    bit                hold_request  = 1'b0;

    adaptive_jitter_latency_estimator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[adaptive_jitter_latency_estimator_top] ERROR");
            $finish;
        end
    end

    // Update the shadow state for one arrival and return the result it causes
    function automatic jitter_result_t predict_arrival(input logic [TIME_W-1:0] now);
        jitter_result_t    r;
        logic [TIME_W-1:0] gap;
        bit                backwards;
        int unsigned       total;
        int unsigned       mean;
        int unsigned       spread;
        int unsigned       d;
        int unsigned       root;
        int unsigned       trial;
        int unsigned       tgt;
        int unsigned       prev_lat;
        r = '0;
        if (!have_arrival) begin
            have_arrival = 1'b1;
            prev_arrival = now;
            r.status     = ST_FIRST;
        end else begin
            backwards    = now < prev_arrival;
            gap          = now - prev_arrival;
            prev_arrival = now;
            if (backwards || gap > TIME_W'(cfg_max_ivl)) begin
                r.status = ST_REJECT;
            end else begin
                ivl_hist[hist_head] = gap[IVL_W-1:0];
                hist_head = (hist_head + 1 >= WINDOW_DEPTH) ? 0 : hist_head + 1;
                if (hist_fill < WINDOW_DEPTH)
                    hist_fill++;
                if (hist_fill < MIN_FILL) begin
                    r.status = ST_WARMUP;
                end else begin
                    total = 0;
                    for (int i = 0; i < hist_fill; i++)
                        total += ivl_hist[i];
                    mean = total / hist_fill;
                    spread = 0;
                    for (int i = 0; i < hist_fill; i++) begin
                        d = (ivl_hist[i] >= mean) ? ivl_hist[i] - mean : mean - ivl_hist[i];
                        spread += d * d;
                    end
                    spread = spread / hist_fill;
                    // Largest root whose square does not exceed the variance
                    root = 0;
                    for (int b = 11; b >= 0; b--) begin
                        trial = root | (32'd1 << b);
                        if (trial * trial <= spread)
                            root = trial;
                    end
                    tgt = mean + 2 * root;
                    if (tgt < cfg_min_lat)
                        tgt = cfg_min_lat;
                    if (tgt > cfg_max_lat)
                        tgt = cfg_max_lat;
                    prev_lat    = cur_latency;
                    cur_latency = LAT_W'((prev_lat * 3 + tgt) / 4);
                    r.status    = ST_UPDATED;
                end
            end
        end
        r.latency = cur_latency;
        r.wcount  = WCNT_W'(hist_fill);
        return r;
    endfunction

    // Offer one arrival, record its expected result, then pause between bursts
    task automatic send_arrival(input logic [TIME_W-1:0] t);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        expected_results = {expected_results, predict_arrival(t)};
        last_sent = t;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
        end
    endtask

    // Write one register through the config channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MIN_LAT: cfg_min_lat = val[LAT_W-1:0];
            REG_MAX_LAT: cfg_max_lat = val[LAT_W-1:0];
            REG_MAX_IVL: cfg_max_ivl = val[IVL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // First arrival at time zero, warm-up, limit edge and first updates
    task automatic test_first_and_warmup();
        send_arrival('0);
        send_arrival(last_sent + 10);
        send_arrival(last_sent + 10);
        send_arrival(last_sent + 200);
        send_arrival(last_sent + 201);
        send_arrival(last_sent + 5);
        send_arrival(last_sent + 7);
        send_arrival(last_sent + 3);
        wait_idle();
    endtask

    // Largest timestamp, time going backwards, then a zero interval
    task automatic test_time_extremes();
        send_arrival({TIME_W{1'b1}});
        send_arrival('0);
        send_arrival('0);
        wait_idle();
    endtask

    // Interval limit of zero, written with high bits that must be dropped
    task automatic test_zero_limit();
        write_reg(REG_MAX_IVL, 10'h300);
        send_arrival(last_sent);
        send_arrival(last_sent + 1);
        send_arrival(last_sent);
        wait_idle();
    endtask

    // Minimum clamp above maximum clamp, then the widest clamp range
    task automatic test_crossed_clamps();
        write_reg(REG_MIN_LAT, 10'h3FF);
        write_reg(REG_MAX_LAT, 10'd5);
        write_reg(REG_MAX_IVL, 10'h0FF);
        send_arrival(last_sent + 255);
        send_arrival(last_sent + 255);
        wait_idle();
        write_reg(REG_MIN_LAT, 10'd0);
        write_reg(REG_MAX_LAT, 10'h3FF);
        send_arrival(last_sent + 1);
        send_arrival(last_sent);
        wait_idle();
    endtask

    // A write past the register list must change nothing
    task automatic test_unmapped_index();
        write_reg(REG_UNMAPPED, 10'h3FF);
        send_arrival(last_sent + 255);
        wait_idle();
    endtask

    // Keep offering while the receiver holds off, so the input stalls
    task automatic test_backpressure();
        @(posedge aclk);
        hold_request = 1'b1;
        burst_left   = 100;
        for (int i = 0; i < 16; i++)
            send_arrival(last_sent + TIME_W'($urandom_range(0, cfg_max_ivl)));
        burst_left = 0;
        wait_idle();
    endtask

    // Phases of fixed and random register settings with mostly well-formed arrival streams
    task automatic test_random_phases();
        logic [TIME_W-1:0] nxt;
        int                base;
        int                spread;
        int                ivl;
        int                pick;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(REG_MIN_LAT, 10'd0);
                    write_reg(REG_MAX_LAT, 10'h3FF);
                    write_reg(REG_MAX_IVL, 10'h0FF);
                end
                1: begin
                    write_reg(REG_MIN_LAT, 10'h3FF);
                    write_reg(REG_MAX_LAT, 10'h3FF);
                    write_reg(REG_MAX_IVL, 10'h3FF);
                end
                2: begin
                    write_reg(REG_MIN_LAT, CFG_DATA_W'($urandom_range(500, 1023)));
                    write_reg(REG_MAX_LAT, CFG_DATA_W'($urandom_range(0, 400)));
                    write_reg(REG_MAX_IVL, CFG_DATA_W'($urandom_range(0, 1023)));
                end
                3: begin
                    write_reg(REG_MIN_LAT, 10'd0);
                    write_reg(REG_MAX_LAT, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_MAX_IVL, 10'd1);
                end
                default: begin
                    write_reg(REG_MIN_LAT, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_MAX_LAT, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_MAX_IVL, CFG_DATA_W'($urandom_range(0, 1023)));
                end
            endcase
            base   = $urandom_range(0, cfg_max_ivl);
            spread = $urandom_range(0, 40);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    // Jittered interval within the limit
                    if ($urandom_range(0, 1) == 0)
                        ivl = $urandom_range(0, cfg_max_ivl);
                    else
                        ivl = base + $urandom_range(0, spread);
                    if (ivl > cfg_max_ivl)
                        ivl = cfg_max_ivl;
                    nxt = last_sent + TIME_W'(ivl);
                end else if (pick < 88) begin
                    nxt = last_sent + TIME_W'(cfg_max_ivl + 1 + $urandom_range(0, 300));
                end else if (pick < 94) begin
                    nxt = last_sent - TIME_W'($urandom_range(1, 1000));
                end else begin
                    nxt = TIME_W'({$urandom, $urandom});
                end
                send_arrival(nxt);
            end
            wait_idle();
        end
    endtask

    // Receiver stall pattern, with a long hold-off on request
    initial begin : rx_stall
        int mode;
        int mode_left;
        int hold_left;
        int pat_cnt;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        pat_cnt   = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(1, 200);
                end
                mode_left--;
                pat_cnt++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (pat_cnt % 5) != 0;
                endcase
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : check_latency_results
        jitter_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, actual latency_ms %0d status %0d count %0d",
                         $time, m_tdata[LAT_W-1:0], m_tuser, m_tdata[LAT_W +: WCNT_W]);
                error_count++;
            end else begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                if (m_tdata[LAT_W-1:0] !== exp_r.latency) begin
                    $display("%0t: latency_ms expected %0d actual %0d",
                             $time, exp_r.latency, m_tdata[LAT_W-1:0]);
                    error_count++;
                end
                if (m_tuser !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[LAT_W +: WCNT_W] !== exp_r.wcount) begin
                    $display("%0t: window_count expected %0d actual %0d",
                             $time, exp_r.wcount, m_tdata[LAT_W +: WCNT_W]);
                    error_count++;
                end
                if (m_tdata[M_TDATA_W-1:LAT_W+WCNT_W] !== '0) begin
                    $display("%0t: tdata padding expected 0 actual %0h",
                             $time, m_tdata[M_TDATA_W-1:LAT_W+WCNT_W]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        // Hold reset, then release on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_first_and_warmup();
        test_time_extremes();
        test_zero_limit();
        test_crossed_clamps();
        test_unmapped_index();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[adaptive_jitter_latency_estimator_top] OK");
        end else begin
            $display("[adaptive_jitter_latency_estimator_top] ERROR");
        end
        $finish;
    end

endmodule
